// File: sv/crccg_pkg.sv
// Shared constants, types and helpers of the CRC codeword generator.
package crccg_pkg;

    localparam int MAX_DEGREE  = 32;
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1) < 6 ? 6 : $clog2(MAX_DEGREE + 1);
    localparam int BITIDX_W    = $clog2(MAX_DEGREE);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_CRC_DEGREE     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GENERATOR_TAPS = 1'b1;

    localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(8);
    localparam logic [31:0]      TAPS_RESET   = 32'd7;

    // One word handed from the front to the back.
    typedef struct packed {
        logic                  msg_bit;
        logic                  msg_last;
        logic [MAX_DEGREE-1:0] rem;
        logic [DEG_W-1:0]      deg;
    } crccg_entry_t;

    // Clamp the programmed degree into 1..MAX_DEGREE.
    function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] d;
        d = deg;
        if (d == '0)
            d = DEG_W'(1);
        else if (d > DEG_W'(MAX_DEGREE))
            d = DEG_W'(MAX_DEGREE);
        return d;
    endfunction

    // Ones in the low d bit positions.
    function automatic logic [MAX_DEGREE-1:0] degree_mask(input logic [DEG_W-1:0] d);
        logic [MAX_DEGREE-1:0] m;
        for (int k = 0; k < MAX_DEGREE; k++)
            m[k] = (DEG_W'(k) < d);
        return m;
    endfunction

endpackage

// File: sv/crccg_front.sv
// Front end: configuration registers, input acceptance and LFSR remainder update.
module crccg_front
    import crccg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_bit,
    input  logic                  in_last,
    output logic                  in_ready,
    input  logic                  q_full,
    output logic                  push,
    output crccg_entry_t          push_entry
);

    logic [DEG_W-1:0]      crc_degree_reg;
    logic [MAX_DEGREE-1:0] generator_taps_reg;
    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;
    logic [MAX_DEGREE-1:0] upd_rem;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] rem_m;
    logic [DEG_W-1:0]      d;
    logic [DEG_W-1:0]      d_m1;
    logic                  fb;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_degree_reg     <= DEGREE_RESET;
            generator_taps_reg <= MAX_DEGREE'(TAPS_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CRC_DEGREE:     crc_degree_reg     <= cfg_wdata[DEG_W-1:0];
                REG_GENERATOR_TAPS: generator_taps_reg <= cfg_wdata[MAX_DEGREE-1:0];
                default:            ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        d       = eff_degree(crc_degree_reg);
        d_m1    = d - DEG_W'(1);
        mask    = degree_mask(d);
        rem_m   = rem_reg & mask;
        fb      = in_bit ^ rem_m[d_m1[BITIDX_W-1:0]];
        upd_rem = (rem_m << 1) & mask;
        if (fb)
            upd_rem = upd_rem ^ (generator_taps_reg & mask);

        rem_next = rem_reg;
        if (push)
            rem_next = in_last ? '0 : upd_rem;

        push_entry.msg_bit  = in_bit;
        push_entry.msg_last = in_last;
        push_entry.rem      = upd_rem;
        push_entry.deg      = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

endmodule

// File: sv/crccg_queue.sv
// Short FIFO that decouples the front end from the serializer.
module crccg_queue
    import crccg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  crccg_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output crccg_entry_t head
);

    crccg_entry_t      slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/crccg_back.sv
// Back end: echo message bits, shift out check bits, hold the output register.
module crccg_back
    import crccg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_not_empty,
    input  crccg_entry_t head,
    output logic         pop,
    output logic         out_valid,
    output logic         out_bit,
    output logic         out_chk,
    output logic         out_last,
    input  logic         out_ready
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_bit_reg;
    logic                  out_bit_next;
    logic                  out_chk_reg;
    logic                  out_chk_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic [DEG_W-1:0]      chk_cnt_reg;
    logic [DEG_W-1:0]      chk_cnt_next;
    logic [MAX_DEGREE-1:0] chk_sr_reg;
    logic [MAX_DEGREE-1:0] chk_sr_next;
    logic [DEG_W-1:0]      idx;
    logic                  load;

    assign load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_chk_next   = out_chk_reg;
        out_last_next  = out_last_reg;
        chk_cnt_next   = chk_cnt_reg;
        chk_sr_next    = chk_sr_reg;
        pop            = 1'b0;
        idx            = chk_cnt_reg - DEG_W'(1);

        if (load)
        begin
            if (chk_cnt_reg != '0)
            begin
                // check bits go out most significant first
                out_valid_next = 1'b1;
                out_bit_next   = chk_sr_reg[idx[BITIDX_W-1:0]];
                out_chk_next   = 1'b1;
                out_last_next  = (chk_cnt_reg == DEG_W'(1));
                chk_cnt_next   = idx;
            end
            else if (q_not_empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                out_bit_next   = head.msg_bit;
                out_chk_next   = 1'b0;
                out_last_next  = 1'b0;
                if (head.msg_last)
                begin
                    chk_cnt_next = head.deg;
                    chk_sr_next  = head.rem;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            chk_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            chk_cnt_reg   <= chk_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg  <= out_bit_next;
        out_chk_reg  <= out_chk_next;
        out_last_reg <= out_last_next;
        chk_sr_reg   <= chk_sr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;
    assign out_chk   = out_chk_reg;
    assign out_last  = out_last_reg;

endmodule

// File: sv/crc_codeword_generator_unit.sv
// Top level of the bit-serial CRC codeword generator with programmable generator.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready | s_tdata[0] msg_bit, s_tlast msg_last
//  m_*      | out       | m_tvalid/m_tready | m_tdata[0] code_bit, m_tuser is_check_bit,
//           |           |                   | m_tlast code_last
//  cfg_*    | in        | cfg_we            | cfg_addr register index, cfg_wdata value
//
// Flow: the front takes one message bit per cycle while the queue has room and
// updates the remainder in the same cycle; the serializer sends one word per cycle
// while m_tready is high, so a message of n bits leaves as n + d words (d = effective
// degree), and the front runs ahead by up to four words held in the queue before it stalls.
// Each input word passes through a queue slot and then the output register.
// Reset clears the remainder, the queue and the output register; degree resets
// to 8 and taps to 7. A stall on m_tready holds the output word and backs up
// through the queue to s_tready. The back also pops nothing while it shifts out
// check bits, so more than four message bits offered behind a last bit drop s_tready.
module crc_codeword_generator_unit
    import crccg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] msg_bit, [7:1] zero
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] code_bit, [7:1] zero
    output logic                  m_tuser,   // [0] is_check_bit
    output logic                  m_tlast
);

    logic         push;
    crccg_entry_t push_entry;
    logic         q_full;
    logic         q_pop;
    logic         q_not_empty;
    crccg_entry_t q_head;
    logic         out_bit;

    // Front: accept message bits and advance the remainder
    crccg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_bit     (s_tdata[0]),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: hold words until the serializer is free
    crccg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Back: echo each bit, then drain the check bits after the last one
    crccg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_bit     (out_bit),
        .out_chk     (m_tuser),
        .out_last    (m_tlast),
        .out_ready   (m_tready)
    );

    assign m_tdata = {7'b0, out_bit};

endmodule

// File: tb/tb.sv
// Testbench for the bit-serial CRC codeword generator: directed table, then random messages.
module tb;
    import crccg_pkg::*;

    // Random message bits after the directed table.
    localparam int RANDOM_BITS = 280;
    // Cycles the receiver holds off once, long enough to back the queue up to s_tready.
    localparam int HOLD_CYCLES = 80;
    // Idle cycles before a register write and after the last word.
    localparam int SETTLE = 4;
    // Cycles with no word moving on either side before the run is called hung.
    // The slowest correct stretch is the long hold-off plus a settle pass and a
    // random sender gap; QUIET_LIMIT takes it several times over.
    localparam int QUIET_LIMIT = 1000;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // One row of the directed table. A word row with typed set carries its
    // check bits read straight off the polynomial; other word rows go to the predictor.
    typedef struct packed {
        row_kind_t             kind;
        logic                  msg_bit;
        logic                  msg_last;
        logic                  typed;
        logic [MAX_DEGREE-1:0] check;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] value;
    } stim_row_t;

    // One codeword word as it should leave the block.
    typedef struct packed {
        logic [7:0] data;
        logic       user;
        logic       last;
    } code_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [0] msg_bit, [7:1] zero
    logic                  s_tlast;     // msg_last
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;     // [0] code_bit, [7:1] zero
    logic                  m_tuser;     // [0] is_check_bit
    logic                  m_tlast;     // code_last

    // Shadow of the block: registers as written, and the running remainder.
    logic [DEG_W-1:0]      shadow_degree;
    logic [31:0]           shadow_taps;
    logic [MAX_DEGREE-1:0] crc_rem;

    // Codeword words predicted but not yet seen, oldest first.
    code_word_t codeword_q[$];

    int  mismatches;
    int  quiet_cycles;
    int  gap_pct;
    int  stall_pct;
    bit  hold_out;

    // Directed table: reset settings first, then the degree and tap corner cases.
    stim_row_t directed_rows [30] = '{
        // Reset degree 8, taps 7: a lone one leaves the taps as the check bits.
        '{ROW_WORD, 1'b1, 1'b1, 1'b1, 32'h0000_0007, REG_CRC_DEGREE, 32'h0},
        // All-zero message gives an all-zero check.
        '{ROW_WORD, 1'b0, 1'b1, 1'b1, 32'h0000_0000, REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b0, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b1, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        // Degree zero runs as degree one: a parity bit.
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_CRC_DEGREE,     32'h0000_0000},
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_GENERATOR_TAPS, 32'hFFFF_FFFF},
        '{ROW_WORD, 1'b1, 1'b1, 1'b1, 32'h0000_0001, REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b1, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        // Largest code saturates to the widest degree.
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_CRC_DEGREE,     32'h0000_003F},
        '{ROW_WORD, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, REG_CRC_DEGREE, 32'h0},
        // No taps: only the leading term divides.
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_GENERATOR_TAPS, 32'h0000_0000},
        '{ROW_WORD, 1'b1, 1'b1, 1'b1, 32'h0000_0000, REG_CRC_DEGREE, 32'h0},
        // Taps at or above the degree drop out.
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_CRC_DEGREE,     32'h0000_0004},
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_GENERATOR_TAPS, 32'hFFFF_FFF3},
        '{ROW_WORD, 1'b1, 1'b1, 1'b1, 32'h0000_0003, REG_CRC_DEGREE, 32'h0},
        // Change the degree halfway through a message; upper data bits are junk.
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b0, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_CRC_DEGREE,     32'hFFFF_FFC6},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b0, 1'b1, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        // A common 16-bit generator.
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_CRC_DEGREE,     32'h0000_0010},
        '{ROW_REG,  1'b0, 1'b0, 1'b0, 32'h0, REG_GENERATOR_TAPS, 32'h0000_1021},
        '{ROW_WORD, 1'b1, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b0, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b0, 1'b0, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0},
        '{ROW_WORD, 1'b1, 1'b1, 1'b0, 32'h0,         REG_CRC_DEGREE, 32'h0}
    };

    crc_codeword_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Degree as the divider uses it: zero counts as one, large codes saturate.
    function automatic int active_degree();
        int d;
        d = shadow_degree;
        if (d == 0)
            d = 1;
        else if (d > MAX_DEGREE)
            d = MAX_DEGREE;
        return d;
    endfunction

    // Shift one message bit through the divider and queue the words it yields:
    // the echo, then on the last bit the check bits, top first. With use_typed
    // the check bits come from the table instead of the running remainder.
    function automatic void divide_bit(input logic b, input logic last,
                                       input logic use_typed,
                                       input logic [MAX_DEGREE-1:0] typed_check);
        int                    d;
        logic [MAX_DEGREE-1:0] mask;
        logic                  fb;
        code_word_t            w;
        d    = active_degree();
        mask = {MAX_DEGREE{1'b1}} >> (MAX_DEGREE - d);
        // Bits above the current degree are dropped, even mid-message.
        crc_rem = crc_rem & mask;
        fb      = b ^ crc_rem[d-1];
        crc_rem = (crc_rem << 1) & mask;
        if (fb)
            crc_rem = crc_rem ^ (shadow_taps[MAX_DEGREE-1:0] & mask);
        w.data = {7'b0, b};
        w.user = 1'b0;
        w.last = 1'b0;
        codeword_q.push_back(w);
        if (last)
        begin
            for (int i = d; i > 0; i--)
            begin
                w.data = {7'b0, use_typed ? typed_check[i-1] : crc_rem[i-1]};
                w.user = 1'b1;
                w.last = (i == 1);
                codeword_q.push_back(w);
            end
            crc_rem = '0;
        end
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Offer one message bit and hold it until the block takes it, then maybe
    // drop valid for a short burst.
    task automatic send_bit(input logic b, input logic last, input logic use_typed,
                            input logic [MAX_DEGREE-1:0] typed_check);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        divide_bit(b, last, use_typed, typed_check);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (codeword_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Registers change only with the block drained.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_CRC_DEGREE)
            shadow_degree = val[DEG_W-1:0];
        else
            shadow_taps = val;
        cfg_we <= 1'b0;
    endtask

    // Receiver: random short stalls, one long hold-off on request, none at the tail.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every word taken from the block against the oldest prediction.
    always @(posedge clk)
    begin
        code_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (codeword_q.size() == 0)
                flag_error($sformatf("unexpected word data=%h user=%b last=%b",
                                     m_tdata, m_tuser, m_tlast));
            else
            begin
                want = codeword_q.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.user || m_tlast !== want.last)
                    flag_error($sformatf({"expected data=%h user=%b last=%b, ",
                                          "got data=%h user=%b last=%b"},
                                         want.data, want.user, want.last,
                                         m_tdata, m_tuser, m_tlast));
            end
        end
    end

    // Hang detector: count cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL crc_codeword_generator_unit");
            $finish;
        end
    end

    initial
    begin
        int               sent;
        int               phase;
        int               budget;
        int               last_odds;
        logic [DEG_W-1:0] deg;
        logic [31:0]      taps;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_out      = 1'b0;
        gap_pct       = 20;
        stall_pct     = 20;
        shadow_degree = DEGREE_RESET;
        shadow_taps   = TAPS_RESET;
        crc_rem       = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            else
                send_bit(directed_rows[r].msg_bit, directed_rows[r].msg_last,
                         directed_rows[r].typed, directed_rows[r].check);
        end

        // Random phases: new registers each phase, messages of mixed length.
        // A phase often ends mid-message, so the next degree takes over a
        // partly built remainder.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BITS)
        begin
            case ($urandom_range(0, 9))
                0:       deg = '0;
                1:       deg = DEG_W'(MAX_DEGREE);
                2:       deg = DEG_W'($urandom_range(MAX_DEGREE + 1, 63));
                3:       deg = DEG_W'(1);
                default: deg = DEG_W'($urandom_range(2, MAX_DEGREE - 1));
            endcase
            case ($urandom_range(0, 5))
                0:       taps = '0;
                1:       taps = '1;
                default: taps = $urandom;
            endcase
            write_reg(REG_CRC_DEGREE, {26'($urandom), deg});
            write_reg(REG_GENERATOR_TAPS, taps);

            case ($urandom_range(0, 2))
                0:       last_odds = 2;
                1:       last_odds = 6;
                default: last_odds = 40;
            endcase
            budget = $urandom_range(15, 35);
            if (RANDOM_BITS - sent <= 40)
            begin
                // Tail of the run: full rate on both sides.
                budget    = RANDOM_BITS - sent;
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 10 * $urandom_range(0, 3);
                stall_pct = 10 * $urandom_range(0, 3);
            end
            // Hold the output off once while the sender keeps pushing.
            if (phase == 1)
                hold_out = 1'b1;

            repeat (budget)
            begin
                send_bit(1'($urandom_range(0, 1)), $urandom_range(1, last_odds) == 1,
                         1'b0, '0);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (codeword_q.size() != 0)
            flag_error($sformatf("%0d words never came out", codeword_q.size()));

        if (mismatches == 0)
            $display("PASS crc_codeword_generator_unit");
        else
            $display("FAIL crc_codeword_generator_unit");
        $finish;
    end

endmodule
